// File: rtl/sdf_pkg.sv
// Package with shared item types and constants of the stream duplicate filter.
package sdf_pkg;

    // Width of the list mark kept with each table entry
    localparam int EPOCH_W = 8;

    // Multiplicative hash constant (golden-ratio based)
    localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } sdf_in_item_t;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic               keep;
        logic               last_out;
        logic               overflow;
    } sdf_out_item_t;

endpackage

// File: rtl/sdf_stream_if.sv
// Valid/ready stream interfaces for the input and result channels.
interface sdf_in_if
    import sdf_pkg::*;
();
    logic         valid;
    logic         ready;
    sdf_in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sdf_out_if
    import sdf_pkg::*;
();
    logic          valid;
    logic          ready;
    sdf_out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/sdf_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module sdf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read; read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/stream_duplicate_filter_unit.sv
// Stream duplicate filter: each input value yields one result telling whether it is the
// first occurrence in the current list (keep) and whether it could not be remembered because
// CAPACITY distinct values are already stored (overflow). Values live in a linear-probing hash
// table in one synchronous RAM of 2**clog2(CAPACITY+1) entries, so at least one slot is always
// free and a probe sequence ends. An item reads its home slot and then one more slot for every occupied slot of a
// different value met on its probe path, one slot per cycle through the single RAM port pair.
// Each entry carries a list mark, so the end of a list clears the table by advancing the mark.
// After reset, and after every 255 lists when the mark wraps, a clearing pass writes every
// entry, one per cycle, and no transaction is accepted meanwhile.
module stream_duplicate_filter_unit
    import sdf_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    sdf_in_if.sink    din,
    sdf_out_if.source dout
);

    localparam int ADDR_W = $clog2(CAPACITY + 1);
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int WORD_W = EPOCH_W + 32;

    localparam logic [ADDR_W-1:0]  CNT_CAP   = ADDR_W'(CAPACITY);
    localparam logic [ADDR_W-1:0]  ADDR_LAST = {ADDR_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_PROBE = 3'b010,
        S_CLEAR = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   probe_reg, probe_next;
    logic [ADDR_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [EPOCH_W-1:0]  epoch_reg, epoch_next;
    sdf_in_item_t        item_reg, item_next;
    logic                out_valid_reg, out_valid_next;
    sdf_out_item_t       out_data_reg, out_data_next;

    logic [31:0]         hash_prod;
    logic [ADDR_W-1:0]   hash_addr;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;
    logic [EPOCH_W-1:0]  rd_epoch;
    logic [31:0]         rd_value;
    logic                slot_used;
    logic                hit;
    logic                out_free;
    logic                has_room;

    // Hash the incoming value to its home slot
    assign hash_prod = 32'(din.data.value * HASH_MULT);
    assign hash_addr = hash_prod[31 -: ADDR_W];

    // Split the returned table word
    assign rd_epoch  = ram_rdata[WORD_W-1 -: EPOCH_W];
    assign rd_value  = ram_rdata[31:0];
    assign slot_used = (rd_epoch == epoch_reg);
    assign hit       = slot_used && (rd_value == item_reg.value);
    assign out_free  = !out_valid_reg || dout.ready;
    assign has_room  = (count_reg < CNT_CAP);

    assign din.ready  = (state_reg == S_IDLE);
    assign dout.valid = out_valid_reg;
    assign dout.data  = out_data_reg;

    sdf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequence lookup, insert, result and clearing pass
    always_comb
    begin
        state_next     = state_reg;
        probe_next     = probe_reg;
        count_next     = count_reg;
        clr_next       = clr_reg;
        epoch_next     = epoch_reg;
        item_next      = item_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = probe_reg;
        ram_wdata      = {epoch_reg, item_reg.value};
        ram_re         = 1'b0;
        ram_raddr      = hash_addr;

        // Retire the held result once taken
        if (out_valid_reg && dout.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                // Accept a transaction and read its home slot
                if (din.valid)
                begin
                    item_next  = din.data;
                    probe_next = hash_addr;
                    ram_re     = 1'b1;
                    state_next = S_PROBE;
                end
            end

            S_PROBE:
            begin
                if (slot_used && !hit)
                begin
                    // Advance to the next slot
                    probe_next = probe_reg + 1'b1;
                    ram_raddr  = probe_reg + 1'b1;
                    ram_re     = 1'b1;
                end
                else if (out_free)
                begin
                    // Resolve: duplicate, insert, or overflow
                    out_valid_next          = 1'b1;
                    out_data_next.value_out = item_reg.value;
                    out_data_next.last_out  = item_reg.last;
                    out_data_next.keep      = !hit;
                    out_data_next.overflow  = !hit && !has_room;
                    if (!hit && has_room)
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                    // Drop the set at the end of the list
                    if (item_reg.last)
                    begin
                        count_next = '0;
                        if (epoch_reg == EPOCH_MAX)
                        begin
                            clr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + 1'b1;
                        end
                    end
                end
            end

            S_CLEAR:
            begin
                // Sweep every entry back to the empty mark
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ADDR_LAST)
                begin
                    epoch_next = EPOCH_ONE;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            count_reg     <= '0;
            clr_reg       <= '0;
            epoch_reg     <= EPOCH_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            clr_reg       <= clr_next;
            epoch_reg     <= epoch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        probe_reg    <= probe_next;
        item_reg     <= item_next;
        out_data_reg <= out_data_next;
    end

endmodule
